// File: rtl/core/fclt_pkg.sv
package fclt_pkg;

  localparam int IN_SIZE  = 32;
  localparam int OUT_SIZE = 16;
  localparam int IN_W     = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int OUT_W    = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
  localparam int ADDR_W   = OUT_W + IN_W;
  localparam int DEPTH    = 1 << ADDR_W;

  localparam logic [15:0]        LR_RESET     = 16'd655;
  localparam logic signed [15:0] BIAS_RESET   = 16'sd41;
  localparam logic [16:0]        MOMENTUM_Q16 = 17'd58982;

  typedef enum logic [2:0] {
    KIND_LOAD_W = 3'd0,
    KIND_LOAD_B = 3'd1,
    KIND_INPUT  = 3'd2,
    KIND_GRAD   = 3'd3,
    KIND_UPDATE = 3'd4,
    KIND_READ_W = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RES_FWD   = 2'd0,
    RES_IGRAD = 2'd1,
    RES_UPD   = 2'd2,
    RES_READ  = 2'd3
  } res_kind_t;

endpackage

// File: rtl/core/fclt_ifs.sv
interface fclt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [5:0]         out_index;
  logic [5:0]         in_index;
  logic signed [15:0] element_value;
  logic [15:0]        batch_count;
  modport source (output valid, kind, out_index, in_index, element_value, batch_count,
                  input ready);
  modport sink (input valid, kind, out_index, in_index, element_value, batch_count,
                output ready);
endinterface

interface fclt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [5:0]         result_index;
  logic signed [15:0] result_value;
  logic               result_last;
  logic               saturated;
  modport source (output valid, result_kind, result_index, result_value, result_last,
                  saturated, input ready);
  modport sink (input valid, result_kind, result_index, result_value, result_last,
                saturated, output ready);
endinterface

interface fclt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] learning_rate;
  modport source (output valid, learning_rate, input ready);
  modport sink (input valid, learning_rate, output ready);
endinterface

// File: rtl/core/fully_connected_layer_trainer.sv
// Dense layer trainer with one shared 35x18 multiplier under a sequencer. After reset all
// 2^(OUT_W+IN_W) = 512 gradient memory entries are cleared, one entry a cycle, before the
// first item is taken. Load, bias and plain input beats are written from S_IDLE. The last
// input element runs the forward pass: S_DOT_RD, S_DOT_MUL, S_DOT_ACC per weight, S_DOT_OUT
// per output. A gradient beat runs S_GRD_RD, S_GRD_MUL, S_GRD_WB per input, then S_GRD_BIAS;
// the last one adds the input gradient pass. Each element needs a read, multiply and sum step,
// as the memory read is registered and the product is registered before it is summed. Update:
// each weight, then bias, runs S_UP_RD, S_UP_MOM, S_UP_NUM, S_UP_PREP, S_UP_DIV (radix-2
// divider) and S_UP_WB. Read beats use S_RW_RD, S_RW_OUT. Results wait in one output register.
module fully_connected_layer_trainer (
  input logic         clk,
  input logic         rst_n,
  fclt_cfg_if.sink    cfg_bus,
  fclt_in_if.sink     in_bus,
  fclt_out_if.source  out_bus
);
  import fclt_pkg::*;

  typedef enum logic [18:0] {
    S_CLR      = 19'h00001,
    S_IDLE     = 19'h00002,
    S_DOT_RD   = 19'h00004,
    S_DOT_MUL  = 19'h00008,
    S_DOT_ACC  = 19'h00010,
    S_DOT_OUT  = 19'h00020,
    S_GRD_RD   = 19'h00040,
    S_GRD_MUL  = 19'h00080,
    S_GRD_WB   = 19'h00100,
    S_GRD_BIAS = 19'h00200,
    S_UP_RD    = 19'h00400,
    S_UP_MOM   = 19'h00800,
    S_UP_NUM   = 19'h01000,
    S_UP_PREP  = 19'h02000,
    S_UP_DIV   = 19'h04000,
    S_UP_WB    = 19'h08000,
    S_UP_OUT   = 19'h10000,
    S_RW_RD    = 19'h20000,
    S_RW_OUT   = 19'h40000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [16:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      sat16 = {1'b1, 16'sh7fff};
    end else if (v < -40'sd32768) begin
      sat16 = {1'b1, 16'sh8000};
    end else begin
      sat16 = {1'b0, v[15:0]};
    end
  endfunction

  state_t state_r, state_nxt;
  logic [OUT_W-1:0] i_r, i_nxt;
  logic [IN_W-1:0]  j_r, j_nxt;
  logic [5:0]  ii_r, ii_nxt;
  logic signed [15:0] val_r, val_nxt;
  logic [15:0] nb_r, nb_nxt;
  logic        bwd_r, bwd_nxt;
  logic        bias_ph_r, bias_ph_nxt;
  logic        sat_acc_r, sat_acc_nxt;
  logic        rw_ok_r, rw_ok_nxt;
  logic [15:0] lr_r, lr_nxt;

  logic signed [39:0] acc_r, acc_nxt;
  logic signed [52:0] prod_r, prod_nxt;
  logic signed [15:0] p_r, p_nxt;
  logic signed [31:0] sum_r, sum_nxt;
  logic [23:0] div_r, div_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic        neg_r, neg_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [5:0]  oidx_r, oidx_nxt;
  logic signed [15:0] oval_r, oval_nxt;
  logic        olast_r, olast_nxt;
  logic        osat_r, osat_nxt;

  logic signed [15:0] bias_r [OUT_SIZE];
  logic signed [31:0] bgs_r  [OUT_SIZE];
  logic signed [31:0] bgp_r  [OUT_SIZE];
  logic signed [15:0] x_r    [IN_SIZE];
  logic signed [15:0] tg_r   [OUT_SIZE];

  logic signed [15:0] wmem [DEPTH];
  logic [63:0]        gmem [DEPTH];
  logic signed [15:0] w_rd_r;
  logic [63:0]        g_rd_r;

  logic               rd_en, wm_we, gm_we;
  logic [ADDR_W-1:0]  wm_addr, g_addr;
  logic signed [15:0] wm_wd;
  logic [63:0]        gm_wd;
  logic               b_we, bgs_we, bgp_we, x_we, tg_we;
  logic [OUT_W-1:0]   b_idx, bgs_idx, tg_idx;
  logic [IN_W-1:0]    x_idx;
  logic signed [15:0] b_wd;
  logic signed [31:0] bgs_wd, bgp_wd;

  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic               in_acc, emit_ok, ok_o, ok_i;
  logic signed [39:0] rnd;
  logic [16:0]        sres;
  logic signed [52:0] mom, mag, adiv;
  logic signed [33:0] msum;
  logic [16:0]        trial;
  logic signed [25:0] upd, pn;
  logic [ADDR_W-1:0]  cnt_inc;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_acc  = in_bus.valid && (state_r == S_IDLE);
  assign emit_ok = !ov_r || out_bus.ready;
  assign ok_o    = {1'b0, in_bus.out_index} < 7'(OUT_SIZE);
  assign ok_i    = {1'b0, in_bus.in_index} < 7'(IN_SIZE);
  assign g_addr  = {i_r, j_r};
  assign cnt_inc = g_addr + ADDR_W'(1);
  assign rnd     = (acc_r + 40'sd2048) >>> 12;
  assign mom     = (prod_r + 53'sd32768) >>> 16;
  assign msum    = {{2{sum_r[31]}}, sum_r} + mom[33:0];
  assign mag     = prod_r[52] ? -prod_r : prod_r;
  assign adiv    = mag + {10'b0, nb_r, 27'b0};
  assign trial   = {rem_r, div_r[23]};
  assign upd     = neg_r ? -$signed({2'b0, div_r}) : $signed({2'b0, div_r});
  assign pn      = {{10{p_r[15]}}, p_r} - upd;

  assign out_bus.valid        = ov_r;
  assign out_bus.result_kind  = okind_r;
  assign out_bus.result_index = oidx_r;
  assign out_bus.result_value = oval_r;
  assign out_bus.result_last  = olast_r;
  assign out_bus.saturated    = osat_r;

  assign prod_nxt = (state_r == S_DOT_MUL || state_r == S_GRD_MUL || state_r == S_UP_MOM ||
                     state_r == S_UP_NUM) ? mul_a * mul_b : prod_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    ii_nxt = ii_r;
    val_nxt = val_r;
    nb_nxt = nb_r;
    bwd_nxt = bwd_r;
    bias_ph_nxt = bias_ph_r;
    sat_acc_nxt = sat_acc_r;
    rw_ok_nxt = rw_ok_r;
    lr_nxt = cfg_bus.valid ? cfg_bus.learning_rate : lr_r;
    acc_nxt = acc_r;
    p_nxt = p_r;
    sum_nxt = sum_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    neg_nxt = neg_r;
    ov_nxt = (ov_r && out_bus.ready) ? 1'b0 : ov_r;
    okind_nxt = okind_r;
    oidx_nxt = oidx_r;
    oval_nxt = oval_r;
    olast_nxt = olast_r;
    osat_nxt = osat_r;
    rd_en = 1'b0;
    wm_we = 1'b0;
    gm_we = 1'b0;
    wm_addr = g_addr;
    wm_wd = val_r;
    gm_wd = g_rd_r;
    b_we = 1'b0;
    b_idx = i_r;
    b_wd = val_r;
    bgs_we = 1'b0;
    bgs_idx = i_r;
    bgs_wd = '0;
    bgp_we = 1'b0;
    bgp_wd = sum_r;
    x_we = 1'b0;
    x_idx = in_bus.in_index[IN_W-1:0];
    tg_we = 1'b0;
    tg_idx = in_bus.out_index[OUT_W-1:0];
    mul_a = '0;
    mul_b = '0;
    sres = '0;
    case (state_r)
      S_CLR: begin
        gm_we = 1'b1;
        gm_wd = '0;
        {i_nxt, j_nxt} = cnt_inc;
        if (g_addr == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          ii_nxt = in_bus.in_index;
          val_nxt = in_bus.element_value;
          nb_nxt = (in_bus.batch_count == 16'd0) ? 16'd1 : in_bus.batch_count;
          case (in_bus.kind)
            KIND_LOAD_W: begin
              if (ok_o && ok_i) begin
                wm_we = 1'b1;
                wm_addr = {in_bus.out_index[OUT_W-1:0], in_bus.in_index[IN_W-1:0]};
                wm_wd = in_bus.element_value;
              end
            end
            KIND_LOAD_B: begin
              if (ok_o) begin
                b_we = 1'b1;
                b_idx = in_bus.out_index[OUT_W-1:0];
                b_wd = in_bus.element_value;
              end
            end
            KIND_INPUT: begin
              if (ok_i) begin
                x_we = 1'b1;
                if (in_bus.in_index == 6'(IN_SIZE - 1)) begin
                  bwd_nxt = 1'b0;
                  i_nxt = '0;
                  j_nxt = '0;
                  state_nxt = S_DOT_RD;
                end
              end
            end
            KIND_GRAD: begin
              if (ok_o) begin
                tg_we = 1'b1;
                i_nxt = in_bus.out_index[OUT_W-1:0];
                j_nxt = '0;
                state_nxt = S_GRD_RD;
              end
            end
            KIND_UPDATE: begin
              i_nxt = '0;
              j_nxt = '0;
              bias_ph_nxt = 1'b0;
              sat_acc_nxt = 1'b0;
              state_nxt = S_UP_RD;
            end
            KIND_READ_W: begin
              rw_ok_nxt = ok_o && ok_i;
              if (ok_o && ok_i) begin
                i_nxt = in_bus.out_index[OUT_W-1:0];
                j_nxt = in_bus.in_index[IN_W-1:0];
                state_nxt = S_RW_RD;
              end else begin
                state_nxt = S_RW_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DOT_RD: begin
        rd_en = 1'b1;
        if (!bwd_r && j_r == '0) begin
          acc_nxt = {{12{bias_r[i_r][15]}}, bias_r[i_r], 12'b0};
        end
        if (bwd_r && i_r == '0) begin
          acc_nxt = '0;
        end
        state_nxt = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        mul_a = bwd_r ? 35'(tg_r[i_r]) : 35'(x_r[j_r]);
        mul_b = 18'(w_rd_r);
        state_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        acc_nxt = acc_r + prod_r[39:0];
        if (!bwd_r) begin
          if (j_r == IN_W'(IN_SIZE - 1)) begin
            state_nxt = S_DOT_OUT;
          end else begin
            j_nxt = j_r + IN_W'(1);
            state_nxt = S_DOT_RD;
          end
        end else begin
          if (i_r == OUT_W'(OUT_SIZE - 1)) begin
            state_nxt = S_DOT_OUT;
          end else begin
            i_nxt = i_r + OUT_W'(1);
            state_nxt = S_DOT_RD;
          end
        end
      end
      S_DOT_OUT: begin
        sres = sat16(rnd);
        if (emit_ok) begin
          ov_nxt = 1'b1;
          okind_nxt = bwd_r ? RES_IGRAD : RES_FWD;
          oidx_nxt = bwd_r ? 6'(j_r) : 6'(i_r);
          oval_nxt = sres[15:0];
          osat_nxt = sres[16];
          if (!bwd_r) begin
            olast_nxt = (i_r == OUT_W'(OUT_SIZE - 1));
            j_nxt = '0;
            i_nxt = i_r + OUT_W'(1);
            state_nxt = (i_r == OUT_W'(OUT_SIZE - 1)) ? S_IDLE : S_DOT_RD;
          end else begin
            olast_nxt = (j_r == IN_W'(IN_SIZE - 1));
            i_nxt = '0;
            j_nxt = j_r + IN_W'(1);
            state_nxt = (j_r == IN_W'(IN_SIZE - 1)) ? S_IDLE : S_DOT_RD;
          end
        end
      end
      S_GRD_RD: begin
        rd_en = 1'b1;
        state_nxt = S_GRD_MUL;
      end
      S_GRD_MUL: begin
        mul_a = 35'(val_r);
        mul_b = 18'(x_r[j_r]);
        state_nxt = S_GRD_WB;
      end
      S_GRD_WB: begin
        gm_we = 1'b1;
        gm_wd = {sat32({{2{g_rd_r[63]}}, g_rd_r[63:32]} + prod_r[33:0]), g_rd_r[31:0]};
        if (j_r == IN_W'(IN_SIZE - 1)) begin
          state_nxt = S_GRD_BIAS;
        end else begin
          j_nxt = j_r + IN_W'(1);
          state_nxt = S_GRD_RD;
        end
      end
      S_GRD_BIAS: begin
        bgs_we = 1'b1;
        bgs_wd = sat32({{2{bgs_r[i_r][31]}}, bgs_r[i_r]} +
                       {{6{val_r[15]}}, val_r, 12'b0});
        if (i_r == OUT_W'(OUT_SIZE - 1)) begin
          bwd_nxt = 1'b1;
          i_nxt = '0;
          j_nxt = '0;
          state_nxt = S_DOT_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UP_RD: begin
        rd_en = !bias_ph_r;
        state_nxt = S_UP_MOM;
      end
      S_UP_MOM: begin
        p_nxt = bias_ph_r ? bias_r[i_r] : w_rd_r;
        sum_nxt = bias_ph_r ? bgs_r[i_r] : g_rd_r[63:32];
        mul_a = bias_ph_r ? 35'(bgp_r[i_r]) : 35'($signed(g_rd_r[31:0]));
        mul_b = $signed({1'b0, MOMENTUM_Q16});
        state_nxt = S_UP_NUM;
      end
      S_UP_NUM: begin
        mul_a = 35'(msum);
        mul_b = $signed({2'b0, lr_r});
        state_nxt = S_UP_PREP;
      end
      S_UP_PREP: begin
        neg_nxt = prod_r[52];
        div_nxt = adiv[51:28];
        rem_nxt = '0;
        dcnt_nxt = '0;
        state_nxt = S_UP_DIV;
      end
      S_UP_DIV: begin
        if (trial >= {1'b0, nb_r}) begin
          rem_nxt = 16'(trial - {1'b0, nb_r});
          div_nxt = {div_r[22:0], 1'b1};
        end else begin
          rem_nxt = trial[15:0];
          div_nxt = {div_r[22:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd23) begin
          state_nxt = S_UP_WB;
        end
      end
      S_UP_WB: begin
        sres = sat16(40'(pn));
        sat_acc_nxt = sat_acc_r | sres[16];
        state_nxt = S_UP_RD;
        if (bias_ph_r) begin
          b_we = 1'b1;
          b_wd = sres[15:0];
          bgs_we = 1'b1;
          bgs_wd = '0;
          bgp_we = 1'b1;
          if (i_r == OUT_W'(OUT_SIZE - 1)) begin
            state_nxt = S_UP_OUT;
          end else begin
            i_nxt = i_r + OUT_W'(1);
          end
        end else begin
          wm_we = 1'b1;
          wm_wd = sres[15:0];
          gm_we = 1'b1;
          gm_wd = {32'b0, sum_r};
          if (j_r == IN_W'(IN_SIZE - 1)) begin
            j_nxt = '0;
            if (i_r == OUT_W'(OUT_SIZE - 1)) begin
              bias_ph_nxt = 1'b1;
              i_nxt = '0;
            end else begin
              i_nxt = i_r + OUT_W'(1);
            end
          end else begin
            j_nxt = j_r + IN_W'(1);
          end
        end
      end
      S_UP_OUT: begin
        if (emit_ok) begin
          ov_nxt = 1'b1;
          okind_nxt = RES_UPD;
          oidx_nxt = '0;
          oval_nxt = '0;
          olast_nxt = 1'b1;
          osat_nxt = sat_acc_r;
          state_nxt = S_IDLE;
        end
      end
      S_RW_RD: begin
        rd_en = 1'b1;
        state_nxt = S_RW_OUT;
      end
      S_RW_OUT: begin
        if (emit_ok) begin
          ov_nxt = 1'b1;
          okind_nxt = RES_READ;
          oidx_nxt = ii_r;
          oval_nxt = rw_ok_r ? w_rd_r : 16'sd0;
          olast_nxt = 1'b1;
          osat_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r <= '0;
      j_r <= '0;
      ov_r <= 1'b0;
      lr_r <= LR_RESET;
      bwd_r <= 1'b0;
      bias_ph_r <= 1'b0;
      sat_acc_r <= 1'b0;
      rw_ok_r <= 1'b0;
      dcnt_r <= '0;
      for (int k = 0; k < OUT_SIZE; k++) begin
        bias_r[k] <= BIAS_RESET;
        bgs_r[k] <= '0;
        bgp_r[k] <= '0;
        tg_r[k] <= '0;
      end
      for (int k = 0; k < IN_SIZE; k++) begin
        x_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      ov_r <= ov_nxt;
      lr_r <= lr_nxt;
      bwd_r <= bwd_nxt;
      bias_ph_r <= bias_ph_nxt;
      sat_acc_r <= sat_acc_nxt;
      rw_ok_r <= rw_ok_nxt;
      dcnt_r <= dcnt_nxt;
      if (b_we) begin
        bias_r[b_idx] <= b_wd;
      end
      if (bgs_we) begin
        bgs_r[bgs_idx] <= bgs_wd;
      end
      if (bgp_we) begin
        bgp_r[i_r] <= bgp_wd;
      end
      if (tg_we) begin
        tg_r[tg_idx] <= in_bus.element_value;
      end
      if (x_we) begin
        x_r[x_idx] <= in_bus.element_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    ii_r <= ii_nxt;
    val_r <= val_nxt;
    nb_r <= nb_nxt;
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    p_r <= p_nxt;
    sum_r <= sum_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    okind_r <= okind_nxt;
    oidx_r <= oidx_nxt;
    oval_r <= oval_nxt;
    olast_r <= olast_nxt;
    osat_r <= osat_nxt;
  end

  // weight and gradient memories, registered read
  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_addr] <= wm_wd;
    end
    if (gm_we) begin
      gmem[g_addr] <= gm_wd;
    end
    if (rd_en) begin
      w_rd_r <= wmem[g_addr];
      g_rd_r <= gmem[g_addr];
    end
  end

endmodule

// File: rtl/core/fclt_checker.sv
module fclt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_kind,
  input logic [5:0]  in_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [5:0]  out_index,
  input logic [15:0] out_value,
  input logic        out_last,
  input logic        out_sat
);
  import fclt_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_index) &&
    $stable(out_value) && $stable(out_last) && $stable(out_sat))
    else $error("result beat changed while stalled");

  // update done beat has a fixed shape
  a_upd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_UPD |-> out_index == 6'd0 && out_value == 16'd0 && out_last)
    else $error("malformed update done beat");

  // read weight beat is a single unsaturated beat
  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_READ |-> out_last && !out_sat)
    else $error("malformed read weight beat");

  // last input element starts the forward pass
  a_fwd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_INPUT && in_index == 6'(IN_SIZE - 1)
    |=> !in_ready)
    else $error("input taken during forward pass");

endmodule

bind fully_connected_layer_trainer fclt_checker u_fclt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_kind   (in_bus.kind),
  .in_index  (in_bus.in_index),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_kind  (out_bus.result_kind),
  .out_index (out_bus.result_index),
  .out_value (out_bus.result_value),
  .out_last  (out_bus.result_last),
  .out_sat   (out_bus.saturated)
);
